### hdl/tvsc_pkg.sv
// Shared types, constants and helpers for the tile viewport sphere coverage unit.
// It depends on nothing else. The tile memory, the divider and the top-level module import it.
package tvsc_pkg;

  localparam int MaxTiles = 256;
  localparam int CFG_DW   = 16;
  localparam int CFG_IW   = 3;
  localparam int DIV_DW   = 52;
  localparam int DIV_QW   = 26;
  localparam int DIV_VW   = 16;
  localparam int FRAC_W   = 16;

  localparam logic [8:0]  K_AZ    = 9'd360;
  localparam logic [8:0]  K_EL    = 9'd180;
  localparam logic [25:0] AZ_LIM  = 26'd11796480;
  localparam logic [25:0] EL_LIM  = 26'd5898240;
  localparam logic [25:0] AZR_LIM = 26'd23592960;
  localparam logic [25:0] ELR_LIM = 26'd11796480;

  typedef enum logic [2:0] {
    CFG_TILES_PER_ROW    = 3'd0,
    CFG_TILES_PER_COLUMN = 3'd1,
    CFG_VIEW_TILES_WIDE  = 3'd2,
    CFG_VIEW_TILES_HIGH  = 3'd3,
    CFG_PICTURE_WIDTH    = 3'd4,
    CFG_PICTURE_HEIGHT   = 3'd5,
    CFG_PROJECTION_ERP   = 3'd6
  } cfg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SPLIT, ST_SPLIT_WAIT, ST_WALK_W, ST_WALK_H, ST_READ0, ST_DRAIN,
    ST_MUL, ST_NUM, ST_DIV_START, ST_DIV_WAIT, ST_PUSH
  } state_t;

  typedef enum logic [1:0] {RD_W, RD_H, RD_ORIGIN} rd_kind_t;

  typedef enum logic [1:0] {OP_AZ, OP_EL, OP_AZR, OP_ELR} div_op_t;

  typedef struct packed {
    logic [15:0] w;
    logic [15:0] h;
  } tile_entry_t;

  typedef struct packed {
    logic              done;
    logic              sat;
    logic [DIV_QW-1:0] quot;
    logic [DIV_VW-1:0] rem;
  } div_res_t;

  function automatic logic [8:0] clamp_count(input logic [8:0] v);
    logic [8:0] r;
    if (v == 9'd0) r = 9'd1;
    else if (v > 9'd256) r = 9'd256;
    else r = v;
    return r;
  endfunction

endpackage

### hdl/tvsc_ifs.sv
// Handshake interfaces for the request and response channels.
// They depend on nothing else.
interface tvsc_req_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [7:0]  tile_index;
  logic [15:0] entry_width;
  logic [15:0] entry_height;
  logic [7:0]  viewport_tile;
  modport source(output valid, mode, tile_index, entry_width, entry_height, viewport_tile,
                 input ready);
  modport sink(input valid, mode, tile_index, entry_width, entry_height, viewport_tile,
               output ready);
endinterface

interface tvsc_rsp_if;
  logic               valid;
  logic               ready;
  logic               shape_type;
  logic signed [24:0] centre_azimuth;
  logic signed [23:0] centre_elevation;
  logic [24:0]        azimuth_range;
  logic [23:0]        elevation_range;
  logic               out_of_grid;
  modport source(output valid, shape_type, centre_azimuth, centre_elevation, azimuth_range,
                 elevation_range, out_of_grid, input ready);
  modport sink(input valid, shape_type, centre_azimuth, centre_elevation, azimuth_range,
               elevation_range, out_of_grid, output ready);
endinterface

### hdl/tvsc_tile_mem.sv
// Tile width and height table: one write port and one registered read port.
// It depends on tvsc_pkg.
module tvsc_tile_mem #(
  parameter int MAX_TILES = tvsc_pkg::MaxTiles,
  parameter int AW = (MAX_TILES > 1) ? $clog2(MAX_TILES) : 1
) (
  input  logic                  clk,
  input  logic                  we,
  input  logic [AW-1:0]         waddr,
  input  tvsc_pkg::tile_entry_t wdata,
  input  logic [AW-1:0]         raddr,
  output tvsc_pkg::tile_entry_t rdata
);
  import tvsc_pkg::*;

  tile_entry_t mem [MAX_TILES];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hdl/tvsc_divider.sv
// Restoring divider, one quotient bit a cycle, with early saturation of large quotients.
// It depends on tvsc_pkg.
module tvsc_divider (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [tvsc_pkg::DIV_DW-1:0] dividend,
  input  logic [tvsc_pkg::DIV_VW-1:0] divisor,
  output tvsc_pkg::div_res_t          res,
  output logic                        busy
);
  import tvsc_pkg::*;

  localparam int CW = $clog2(DIV_QW);

  logic [CW-1:0]     cnt;
  logic [DIV_VW-1:0] dvs;
  logic [DIV_VW-1:0] remr;
  logic [DIV_QW-1:0] low;
  logic [DIV_QW-1:0] quot;
  logic              sat;
  logic              done;
  logic [DIV_VW:0]   trial;
  logic              ge;
  logic [DIV_VW:0]   diff;
  logic              big;

  assign trial = {remr, low[DIV_QW-1]};
  assign ge    = trial >= {1'b0, dvs};
  assign diff  = trial - {1'b0, dvs};
  assign big   = dividend[DIV_DW-1:DIV_QW] >= {{(DIV_DW-DIV_QW-DIV_VW){1'b0}}, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= !big;
        done <= big;
      end else if (busy && cnt == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvs  <= divisor;
      sat  <= big;
      quot <= '1;
      remr <= dividend[DIV_QW+DIV_VW-1:DIV_QW];
      low  <= dividend[DIV_QW-1:0];
      cnt  <= CW'(DIV_QW - 1);
    end else if (busy) begin
      remr <= ge ? diff[DIV_VW-1:0] : trial[DIV_VW-1:0];
      low  <= {low[DIV_QW-2:0], 1'b0};
      quot <= {quot[DIV_QW-2:0], ge};
      cnt  <= cnt - 1'b1;
    end
  end

  assign res = '{done: done, sat: sat, quot: quot, rem: remr};

endmodule

### hdl/tile_viewport_sphere_coverage_unit.sv
// Tile viewport sphere coverage unit: tile size table and coverage computation.
// It depends on tvsc_pkg, tvsc_ifs, tvsc_tile_mem and tvsc_divider.
//
// The request channel carries load words (mode 0), which write one tile entry, and
// query words (mode 1), which name the viewport's top-left tile. Each query yields one
// response word with the coverage centre and range in units of 1/65536 degree; loads
// yield none. Configuration registers are written through cfg_we, cfg_index and
// cfg_data; the user must write them only while the unit is idle, as the unit does
// not enforce this. A query first splits the tile index into row and column on the
// divider, then walks VW entries of the width table and VH entries of the height
// table through the table's single read port, then runs four divisions on the same
// shared bit-serial divider; a division ends early when its quotient saturates. A
// tile outside the grid goes from the split straight to the response.
// One word is worked on at a time; the request side is ready only when idle.
// The response sits in an output register; while the receiver stalls, a finished query
// waits until that register is free.
// Reset is synchronous; it restores the register defaults and empties the pipeline. The
// tile table is not cleared and must be loaded before it is used.
module tile_viewport_sphere_coverage_unit #(
  parameter int MAX_TILES = tvsc_pkg::MaxTiles
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [tvsc_pkg::CFG_IW-1:0] cfg_index,
  input  logic [tvsc_pkg::CFG_DW-1:0] cfg_data,
  tvsc_req_if.sink                    req,
  tvsc_rsp_if.source                  rsp
);
  import tvsc_pkg::*;

  localparam int AW = (MAX_TILES > 1) ? $clog2(MAX_TILES) : 1;

  logic [8:0]  tpr, tpc, vtw, vth;
  logic [15:0] pw, ph;
  logic        erp;
  logic [8:0]  r, c, vw, vh;
  logic [15:0] pwe, phe;

  state_t state, state_next;

  logic [7:0]  vt, row, col, cc, rr;
  logic [15:0] rowbase;
  logic [16:0] base;
  logic [8:0]  k;
  logic [23:0] sw, sh, left, top;
  logic [15:0] w0, h0;
  logic signed [26:0] numa, nume;
  div_op_t op;
  logic        dneg;
  logic signed [24:0] az, azr;
  logic signed [23:0] el, elr;
  logic        oog;

  logic        iss;
  logic [16:0] iss_idx;
  rd_kind_t    iss_kind;
  logic        rv, roor;
  rd_kind_t    rkind;
  tile_entry_t rdata;
  logic        we;
  tile_entry_t wdata;

  logic              div_start, div_busy;
  logic [DIV_DW-1:0] dividend;
  logic [DIV_VW-1:0] divisor;
  div_res_t          dres;
  logic signed [26:0] sel;
  logic [26:0]       mag;
  logic [35:0]       prod;
  logic [25:0]       qm;
  logic [25:0]       lim;

  logic accept;
  logic ov;

  always_ff @(posedge clk) begin
    if (rst) begin
      tpr <= 9'd1;
      tpc <= 9'd1;
      vtw <= 9'd1;
      vth <= 9'd1;
      pw  <= 16'd3840;
      ph  <= 16'd1920;
      erp <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_TILES_PER_ROW:    tpr <= cfg_data[8:0];
        CFG_TILES_PER_COLUMN: tpc <= cfg_data[8:0];
        CFG_VIEW_TILES_WIDE:  vtw <= cfg_data[8:0];
        CFG_VIEW_TILES_HIGH:  vth <= cfg_data[8:0];
        CFG_PICTURE_WIDTH:    pw  <= cfg_data;
        CFG_PICTURE_HEIGHT:   ph  <= cfg_data;
        CFG_PROJECTION_ERP:   erp <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign r   = clamp_count(tpr);
  assign c   = clamp_count(tpc);
  assign vw  = clamp_count(vtw);
  assign vh  = clamp_count(vth);
  assign pwe = (pw == 16'd0) ? 16'd1 : pw;
  assign phe = (ph == 16'd0) ? 16'd1 : ph;

  assign accept = req.valid && req.ready;
  assign we     = accept && !req.mode && ({9'd0, req.tile_index} < 17'(MAX_TILES));
  assign wdata  = '{w: req.entry_width, h: req.entry_height};

  tvsc_tile_mem #(.MAX_TILES(MAX_TILES), .AW(AW)) u_mem (
    .clk  (clk),
    .we   (we),
    .waddr(AW'(req.tile_index)),
    .wdata(wdata),
    .raddr(iss_idx[AW-1:0]),
    .rdata(rdata)
  );

  tvsc_divider u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .dividend(dividend),
    .divisor (divisor),
    .res     (dres),
    .busy    (div_busy)
  );

  always_comb begin
    state_next = state;
    req.ready  = 1'b0;
    div_start  = 1'b0;
    iss        = 1'b0;
    iss_idx    = '0;
    iss_kind   = RD_W;
    unique case (state)
      ST_IDLE: begin
        req.ready = 1'b1;
        if (req.valid && req.mode) state_next = ST_SPLIT;
      end
      ST_SPLIT: begin
        div_start  = 1'b1;
        state_next = ST_SPLIT_WAIT;
      end
      ST_SPLIT_WAIT: begin
        if (dres.done) begin
          state_next = (dres.quot >= {17'd0, c}) ? ST_PUSH : ST_WALK_W;
        end
      end
      ST_WALK_W: begin
        iss      = 1'b1;
        iss_idx  = {1'b0, rowbase} + {9'd0, cc};
        iss_kind = RD_W;
        if (k == vw - 9'd1) state_next = ST_WALK_H;
      end
      ST_WALK_H: begin
        iss      = 1'b1;
        iss_idx  = base;
        iss_kind = RD_H;
        if (k == vh - 9'd1) state_next = ST_READ0;
      end
      ST_READ0: begin
        iss        = 1'b1;
        iss_kind   = RD_ORIGIN;
        state_next = ST_DRAIN;
      end
      ST_DRAIN:     state_next = ST_MUL;
      ST_MUL:       state_next = ST_NUM;
      ST_NUM:       state_next = ST_DIV_START;
      ST_DIV_START: begin
        div_start  = 1'b1;
        state_next = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (dres.done) state_next = (op == OP_ELR) ? ST_PUSH : ST_DIV_START;
      end
      ST_PUSH: begin
        if (!ov || rsp.ready) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  always_comb begin
    unique case (op)
      OP_AZ:   sel = numa;
      OP_EL:   sel = nume;
      OP_AZR:  sel = 27'(sw);
      default: sel = 27'(sh);
    endcase
    mag  = sel[26] ? 27'(-sel) : 27'(sel);
    prod = 36'(mag) * 36'((op == OP_AZ || op == OP_AZR) ? K_AZ : K_EL);
    if (state == ST_SPLIT) begin
      dividend = DIV_DW'(vt);
      divisor  = DIV_VW'(r);
    end else begin
      dividend = {prod[DIV_DW-FRAC_W-1:0], {FRAC_W{1'b0}}};
      divisor  = (op == OP_AZ || op == OP_AZR) ? pwe : phe;
    end
    unique case (op)
      OP_AZ:   lim = AZ_LIM;
      OP_EL:   lim = EL_LIM;
      OP_AZR:  lim = AZR_LIM;
      default: lim = ELR_LIM;
    endcase
    qm = (dres.sat || dres.quot > lim) ? lim : dres.quot;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rv <= 1'b0;
    end else begin
      rv <= iss;
    end
    roor  <= iss_idx >= 17'(MAX_TILES);
    rkind <= iss_kind;
  end

  always_ff @(posedge clk) begin
    if (accept) vt <= req.viewport_tile;
    if (state == ST_SPLIT) begin
      sw  <= '0;
      sh  <= '0;
      oog <= 1'b0;
    end
    if (state == ST_SPLIT_WAIT && dres.done) begin
      row     <= dres.quot[7:0];
      col     <= dres.rem[7:0];
      cc      <= dres.rem[7:0];
      rowbase <= 16'(dres.quot[7:0] * r);
      k       <= '0;
      az      <= '0;
      el      <= '0;
      azr     <= '0;
      elr     <= '0;
      oog     <= dres.quot >= {17'd0, c};
    end
    if (state == ST_WALK_W) begin
      cc <= ({1'b0, cc} + 9'd1 == r) ? 8'd0 : cc + 8'd1;
      if (k == vw - 9'd1) begin
        k    <= '0;
        rr   <= row;
        base <= {9'd0, vt};
      end else begin
        k <= k + 9'd1;
      end
    end
    if (state == ST_WALK_H) begin
      k <= k + 9'd1;
      if ({1'b0, rr} + 9'd1 == c) begin
        rr   <= '0;
        base <= {9'd0, col};
      end else begin
        rr   <= rr + 8'd1;
        base <= base + {8'd0, r};
      end
    end
    if (rv) begin
      unique case (rkind)
        RD_W:    if (!roor) sw <= sw + {8'd0, rdata.w};
        RD_H:    if (!roor) sh <= sh + {8'd0, rdata.h};
        default: begin
          w0 <= rdata.w;
          h0 <= rdata.h;
        end
      endcase
    end
    if (state == ST_MUL) begin
      left <= 24'(col * w0);
      top  <= 24'(row * h0);
    end
    if (state == ST_NUM) begin
      numa <= $signed(27'(pwe[15:1]) - (27'(left) + 27'(sw[23:1])));
      nume <= $signed(27'(phe[15:1]) - (27'(top) + 27'(sh[23:1])));
      op   <= OP_AZ;
    end
    if (state == ST_DIV_START) dneg <= sel[26];
    if (state == ST_DIV_WAIT && dres.done) begin
      unique case (op)
        OP_AZ:   az  <= dneg ? -$signed(25'(qm)) : $signed(25'(qm));
        OP_EL:   el  <= dneg ? -$signed(24'(qm)) : $signed(24'(qm));
        OP_AZR:  azr <= $signed(25'(qm));
        default: elr <= $signed(24'(qm));
      endcase
      op <= div_op_t'(op + 2'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
    end else if (state == ST_PUSH && (!ov || rsp.ready)) begin
      ov <= 1'b1;
    end else if (rsp.ready) begin
      ov <= 1'b0;
    end
    if (state == ST_PUSH && (!ov || rsp.ready)) begin
      rsp.shape_type       <= erp;
      rsp.centre_azimuth   <= az;
      rsp.centre_elevation <= el;
      rsp.azimuth_range    <= azr;
      rsp.elevation_range  <= elr;
      rsp.out_of_grid      <= oog;
    end
  end

  assign rsp.valid = ov;

  a_rsp_from_push: assert property (@(posedge clk) disable iff (rst)
    (ov && (!$past(ov) || $past(rsp.ready))) |-> $past(state) == ST_PUSH)
    else $error("response loaded outside the push step");

  a_oog_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.out_of_grid) |-> (rsp.centre_azimuth == '0 &&
      rsp.centre_elevation == '0 && rsp.azimuth_range == '0 && rsp.elevation_range == '0))
    else $error("out-of-grid response carries coverage values");

  a_div_idle_start: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_busy)
    else $error("divider started while busy");

  a_range_limit: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> (rsp.azimuth_range <= 25'(AZR_LIM) && rsp.elevation_range <= 24'(ELR_LIM)))
    else $error("coverage range beyond its limit");

endmodule
